@@ hw/rtl/abtr_pkg.sv @@
`default_nettype none

package abtr_pkg;

    localparam int DEFAULT_MAP_ROWS    = 256;
    localparam int DEFAULT_MAX_COLUMNS = 16;

    localparam int ROW_W    = 16;
    localparam int INDEX_W  = 8;
    localparam int COLS_W   = 5;
    localparam int OFFSET_W = 12;
    localparam int TILE_W   = 16;

    localparam logic [TILE_W-1:0] PALETTE_BIT = 16'h1000;
    localparam logic [TILE_W-1:0] SOLID_BASE  = 16'd64;
    localparam logic [COLS_W-1:0] COLS_RESET  = 5'd16;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_CUR,
        ST_RD_UP,
        ST_RD_DN,
        ST_START
    } ctrl_state_t;

    // Handoff from the row sequencer to the entry generator.
    typedef struct packed {
        logic              start;
        logic [4:0]        row_lo;
        logic [COLS_W-1:0] width;
        logic [ROW_W-1:0]  cur;
        logic [ROW_W-1:0]  up;
        logic [ROW_W-1:0]  down;
    } gen_start_t;

    // Offset step of each of the four entries of one cell.
    function automatic logic [5:0] entry_step(input logic [1:0] k);
        logic [5:0] s;
        unique case (k)
            2'd0:    s = 6'd0;
            2'd1:    s = 6'd1;
            2'd2:    s = 6'd32;
            default: s = 6'd33;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bitmask_autotile_row_renderer.sv @@
`default_nettype none
// Load items produce no transfer; the row word is written on acceptance.
// Render items: three memory reads (current, above, below row), then the generator start;
// the entries follow one per cycle while m_ready is high, 4*columns_in_use transfers in all
// (column count saturated to MAX_COLUMNS).
// The next item is taken once the last entry sits in the output register.
// Reset (aresetn, synchronous, active low) clears every memory row in a sweep; items wait.

module bitmask_autotile_row_renderer #(
    parameter int MAP_ROWS    = abtr_pkg::DEFAULT_MAP_ROWS,
    parameter int MAX_COLUMNS = abtr_pkg::DEFAULT_MAX_COLUMNS
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire [abtr_pkg::COLS_W-1:0]    cfg_data,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire                           s_opcode,
    input  wire [abtr_pkg::INDEX_W-1:0]   s_row_index,
    input  wire [abtr_pkg::ROW_W-1:0]     s_row_cells,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [abtr_pkg::OFFSET_W-1:0] m_map_offset,
    output logic [abtr_pkg::TILE_W-1:0]   m_tile_entry,
    output logic                          m_last_of_row
);
    import abtr_pkg::*;

    localparam int AW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam logic [COLS_W-1:0] MAX_COLS = COLS_W'(MAX_COLUMNS);
    localparam logic [AW-1:0]     LAST_ROW = AW'(MAP_ROWS - 1);

    ctrl_state_t state_reg, state_next;

    logic [COLS_W-1:0]  cols_reg;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [INDEX_W-1:0] row_reg;
    logic               cur_ok_reg, up_top_reg, up_ok_reg, dn_ok_reg;
    logic [ROW_W-1:0]   cur_reg, up_reg;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [ROW_W-1:0]   mem_wdata, mem_rdata;

    gen_start_t         gen_start;
    logic               gen_busy;
    logic               s_xfer;
    logic [COLS_W-1:0]  width_sat;

    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign width_sat = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;

    // Register write: the field is five bits wide, saturation happens at render start.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= COLS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cols_reg <= cfg_data;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ROW) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_xfer && (s_opcode == OP_RENDER)) begin
                    state_next = ST_RD_CUR;
                end
            end
            ST_RD_CUR: state_next = ST_RD_UP;
            ST_RD_UP:  state_next = ST_RD_DN;
            ST_RD_DN:  state_next = ST_START;
            ST_START:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory ports, input ready and generator start.
    always_comb begin
        s_ready         = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = AW'(s_row_index);
        mem_wdata       = s_row_cells;
        mem_raddr       = AW'(row_reg);
        gen_start       = '0;
        gen_start.row_lo = row_reg[4:0];
        gen_start.width = width_sat;
        gen_start.cur   = cur_reg;
        gen_start.up    = up_reg;
        gen_start.down  = dn_ok_reg ? mem_rdata : '0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                s_ready = !gen_busy;
                // Drop loads beyond the map.
                mem_we  = s_xfer && (s_opcode == OP_LOAD) && (32'(s_row_index) < MAP_ROWS);
            end
            ST_RD_CUR: mem_raddr = AW'(row_reg);
            ST_RD_UP:  mem_raddr = AW'(row_reg - 8'd1);
            ST_RD_DN:  mem_raddr = AW'({1'b0, row_reg} + 9'd1);
            ST_START:  gen_start.start = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // Hold the render row and its range checks; capture read data as it returns.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            row_reg    <= s_row_index;
            cur_ok_reg <= 32'(s_row_index) < MAP_ROWS;
            up_top_reg <= (s_row_index == '0);
            up_ok_reg  <= 32'(s_row_index) <= MAP_ROWS;
            dn_ok_reg  <= (32'(s_row_index) + 32'd1) < MAP_ROWS;
        end
        if (state_reg == ST_RD_UP) begin
            cur_reg <= cur_ok_reg ? mem_rdata : '0;
        end
        if (state_reg == ST_RD_DN) begin
            // Row above row 0 counts as solid.
            up_reg <= up_top_reg ? '1 : (up_ok_reg ? mem_rdata : '0);
        end
    end

    abtr_row_mem #(
        .DEPTH(MAP_ROWS),
        .AW   (AW)
    ) u_mem (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    abtr_entry_gen u_gen (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start_i      (gen_start),
        .busy         (gen_busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_map_offset (m_map_offset),
        .m_tile_entry (m_tile_entry),
        .m_last_of_row(m_last_of_row)
    );

`ifndef SYNTHESIS
    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_start.start |-> !gen_busy)
        else $error("generator started while busy");

    a_no_output_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !m_valid)
        else $error("transfer offered during clearing sweep");

    a_palette_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_tile_entry[12])
        else $error("tile entry without palette bit");

    a_last_is_step33: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_of_row) |-> (m_map_offset[0] && m_map_offset[5]))
        else $error("row end flagged on an entry other than the last of a cell");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/abtr_row_mem.sv @@
`default_nettype none

module abtr_row_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire                        aclk,
    input  wire                        we,
    input  wire [AW-1:0]               waddr,
    input  wire [abtr_pkg::ROW_W-1:0]  wdata,
    input  wire [AW-1:0]               raddr,
    output logic [abtr_pkg::ROW_W-1:0] rdata
);
    import abtr_pkg::*;

    logic [ROW_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/abtr_entry_gen.sv @@
`default_nettype none

module abtr_entry_gen (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire abtr_pkg::gen_start_t   start_i,
    output logic                        busy,
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic [abtr_pkg::OFFSET_W-1:0] m_map_offset,
    output logic [abtr_pkg::TILE_W-1:0] m_tile_entry,
    output logic                        m_last_of_row
);
    import abtr_pkg::*;

    logic                active_reg, active_next;
    logic [3:0]          col_reg, col_next;
    logic [1:0]          k_reg, k_next;
    logic [COLS_W-1:0]   width_reg;
    logic [4:0]          row_lo_reg;
    logic [ROW_W-1:0]    cur_reg, up_reg, down_reg;
    logic                valid_reg, valid_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic [TILE_W-1:0]   tile_reg;
    logic                last_reg;

    logic [COLS_W-1:0]   col_p1;
    logic                right, left, solid;
    logic [3:0]          mask;
    logic [TILE_W-1:0]   tile_base;
    logic [5:0]          step;
    logic [OFFSET_W-1:0] base;
    logic                last_entry;
    logic                load_out;

    always_comb begin
        col_p1     = {1'b0, col_reg} + 5'd1;
        solid      = cur_reg[col_reg];
        right      = (col_p1 >= width_reg) || cur_reg[col_reg + 4'd1];
        left       = (col_reg == 4'd0) || cur_reg[col_reg - 4'd1];
        mask       = {down_reg[col_reg], left, up_reg[col_reg], right};
        tile_base  = solid ? (PALETTE_BIT | (SOLID_BASE + {11'd0, mask, 1'b0})) : PALETTE_BIT;
        step       = entry_step(k_reg);
        base       = {row_lo_reg[4], 1'b0, row_lo_reg[3:0], 1'b0, col_reg, 1'b0};
        last_entry = (col_p1 == width_reg) && (k_reg == 2'd3);
        load_out   = active_reg && (!valid_reg || m_ready);
    end

    always_comb begin
        active_next = active_reg;
        col_next    = col_reg;
        k_next      = k_reg;
        valid_next  = valid_reg;
        if (start_i.start) begin
            active_next = (start_i.width != '0);
            col_next    = '0;
            k_next      = '0;
        end else if (load_out) begin
            k_next = k_reg + 2'd1;
            if (k_reg == 2'd3) begin
                col_next = col_reg + 4'd1;
            end
            if (last_entry) begin
                active_next = 1'b0;
            end
        end
        if (load_out) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            col_reg    <= '0;
            k_reg      <= '0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
            col_reg    <= col_next;
            k_reg      <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start_i.start) begin
            width_reg  <= start_i.width;
            row_lo_reg <= start_i.row_lo;
            cur_reg    <= start_i.cur;
            up_reg     <= start_i.up;
            down_reg   <= start_i.down;
        end
        if (load_out) begin
            offset_reg <= base + {6'd0, step};
            tile_reg   <= tile_base + {10'd0, step};
            last_reg   <= last_entry;
        end
    end

    assign busy          = active_reg;
    assign m_valid       = valid_reg;
    assign m_map_offset  = offset_reg;
    assign m_tile_entry  = tile_reg;
    assign m_last_of_row = last_reg;

endmodule

`default_nettype wire

@@ dv/bitmask_autotile_row_renderer_tb.sv @@
`timescale 1ns / 1ps

module bitmask_autotile_row_renderer_tb;

    import abtr_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int MAP_ROWS       = DEFAULT_MAP_ROWS;
    localparam int MAX_COLUMNS    = DEFAULT_MAX_COLUMNS;
    // A render item with no columns still walks its row reads; give it room.
    localparam int SETTLE_CYCLES  = 16;
    // Longest quiet stretch is the clearing sweep of every map row after reset.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TOTAL_ITEMS    = 420;
    localparam int PHASE_ITEMS    = 50;
    localparam int IDLE_PCT       = 32;

    // One map entry as it leaves the block.
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [TILE_W-1:0]   tile;
        logic                last;
    } map_entry_t;

    // Tracks the collision map and column count, and queues the map entries
    // each render item must produce.
    class autotile_scoreboard;
        logic [ROW_W-1:0]  collision_rows [MAP_ROWS];
        logic [COLS_W-1:0] columns_in_use;
        map_entry_t        pending_entries [$];
        int unsigned       errors;

        function new();
            foreach (collision_rows[i]) collision_rows[i] = '0;
            columns_in_use = COLS_RESET;
            errors = 0;
        endfunction

        function void set_columns(input logic [COLS_W-1:0] value);
            columns_in_use = value;
        endfunction

        // Rows outside the map read as empty.
        function logic [ROW_W-1:0] row_word(input int r);
            if (r >= 0 && r < MAP_ROWS) return collision_rows[r];
            return '0;
        endfunction

        function void note_item(input logic op, input logic [INDEX_W-1:0] row,
                                input logic [ROW_W-1:0] cells);
            int               width;
            int               r;
            int               step;
            logic [ROW_W-1:0] cur;
            logic [ROW_W-1:0] up;
            logic [ROW_W-1:0] down;
            logic [3:0]       mask;
            logic [TILE_W-1:0]   tile;
            logic [OFFSET_W-1:0] base;
            map_entry_t       entry;

            r = int'(row);
            if (op == OP_LOAD) begin
                if (r < MAP_ROWS) collision_rows[r] = cells;
                return;
            end
            width = (columns_in_use > MAX_COLUMNS) ? MAX_COLUMNS : int'(columns_in_use);
            cur  = row_word(r);
            up   = (r == 0) ? '1 : row_word(r - 1);
            down = row_word(r + 1);
            for (int j = 0; j < width; j++) begin
                tile = PALETTE_BIT;
                if (cur[j]) begin
                    mask = '0;
                    if (j + 1 >= width) mask[0] = 1'b1;
                    else                mask[0] = cur[j + 1];
                    mask[1] = up[j];
                    if (j == 0) mask[2] = 1'b1;
                    else        mask[2] = cur[j - 1];
                    mask[3] = down[j];
                    tile = PALETTE_BIT | (SOLID_BASE + {11'd0, mask, 1'b0});
                end
                base = OFFSET_W'(row[3:0]) * 12'd64 + OFFSET_W'(j) * 12'd2
                     + (row[4] ? 12'd2048 : 12'd0);
                for (int k = 0; k < 4; k++) begin
                    step = ((k & 2) != 0 ? 32 : 0) + (k & 1);
                    entry.offset = base + OFFSET_W'(step);
                    entry.tile   = tile + TILE_W'(step);
                    entry.last   = 1'b0;
                    pending_entries.push_back(entry);
                end
            end
            if (width > 0) pending_entries[$].last = 1'b1;
        endfunction

        function void check_entry(input logic [OFFSET_W-1:0] offset,
                                  input logic [TILE_W-1:0] tile, input logic last);
            map_entry_t exp_entry;
            if (pending_entries.size() == 0) begin
                errors++;
                $display("%0t: unexpected entry offset %0d tile %h last %b",
                         $time, offset, tile, last);
                return;
            end
            exp_entry = pending_entries.pop_front();
            if (exp_entry.offset !== offset) begin
                errors++;
                $display("%0t: map_offset expected %0d actual %0d",
                         $time, exp_entry.offset, offset);
            end
            if (exp_entry.tile !== tile) begin
                errors++;
                $display("%0t: tile_entry expected %h actual %h",
                         $time, exp_entry.tile, tile);
            end
            if (exp_entry.last !== last) begin
                errors++;
                $display("%0t: last_of_row expected %b actual %b",
                         $time, exp_entry.last, last);
            end
        endfunction
    endclass

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    logic [COLS_W-1:0]   cfg_data    = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic                s_opcode    = OP_LOAD;
    logic [INDEX_W-1:0]  s_row_index = '0;
    logic [ROW_W-1:0]    s_row_cells = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [OFFSET_W-1:0] m_map_offset;
    logic [TILE_W-1:0]   m_tile_entry;
    logic                m_last_of_row;

    autotile_scoreboard sb;
    int unsigned        cycle_count  = 0;
    int unsigned        quiet_cycles = 0;
    int unsigned        items_sent   = 0;
    logic               calm;

    // Long stretch where neither side idles.
    assign calm = (cycle_count >= 2000) && (cycle_count < 4000);

    bitmask_autotile_row_renderer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_row_index   (s_row_index),
        .s_row_cells   (s_row_cells),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_map_offset  (m_map_offset),
        .m_tile_entry  (m_tile_entry),
        .m_last_of_row (m_last_of_row)
    );

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Result side: check each transfer against the oldest expected entry,
    // then randomly hold off ready for the next cycle outside the calm stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                sb.check_entry(m_map_offset, m_tile_entry, m_last_of_row);
            end
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: count cycles with no transfer on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("bitmask_autotile_row_renderer_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Random row contents of varied density: sparse, dense, plain, or a solid/empty run.
    function automatic logic [ROW_W-1:0] cell_pattern();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        a = ROW_W'($urandom);
        b = ROW_W'($urandom);
        case ($urandom_range(4))
            0:       return a & b;
            1:       return a | b;
            2:       return $urandom_range(1) ? '1 : '0;
            default: return a;
        endcase
    endfunction

    // Present one item and hold it until the transfer; valid stays high on return
    // so back-to-back items need no second assignment in the same step.
    task automatic send_item(input logic op, input logic [INDEX_W-1:0] row,
                             input logic [ROW_W-1:0] cells);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_row_index <= row;
        s_row_cells <= cells;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(op, row, cells);
        items_sent++;
    endtask

    // Drop valid and hold until every expected entry is back, then let the
    // block finish any item that produces no transfer.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_entries.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Column count changes only while the block is idle.
    task automatic write_columns(input logic [COLS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_columns(value);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [INDEX_W-1:0] anchor;
        logic [INDEX_W-1:0] r;
        logic [COLS_W-1:0]  cols;
        int                 phase;
        int                 phase_start;

        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: borders, block halves, extremes of the column count.
        write_columns(COLS_RESET);
        send_item(OP_RENDER, 8'd0, 16'h0000);      // never-loaded map reads empty
        send_item(OP_LOAD, 8'd0, 16'hFFFF);
        send_item(OP_LOAD, 8'd1, 16'h0000);
        send_item(OP_RENDER, 8'd0, 16'h1234);      // row_cells ignored on render
        send_item(OP_LOAD, 8'd255, 16'hFFFF);
        send_item(OP_LOAD, 8'd254, 16'h5A5A);
        send_item(OP_RENDER, 8'd255, 16'hFFFF);    // row below the map is empty
        send_item(OP_RENDER, 8'd254, 16'h0000);
        send_item(OP_LOAD, 8'd15, 16'h0FF0);
        send_item(OP_LOAD, 8'd16, 16'hA5C3);
        send_item(OP_LOAD, 8'd17, 16'hF00F);
        send_item(OP_RENDER, 8'd16, 16'h0000);     // lower half of the block map
        send_item(OP_RENDER, 8'd15, 16'h0000);
        send_item(OP_RENDER, 8'd17, 16'h0000);
        send_item(OP_LOAD, 8'd31, 16'h8001);
        send_item(OP_RENDER, 8'd31, 16'h0000);
        send_item(OP_RENDER, 8'd32, 16'h0000);
        wait_idle();
        write_columns(5'd1);                        // right border right after column 0
        send_item(OP_RENDER, 8'd0, 16'h0000);
        send_item(OP_RENDER, 8'd16, 16'h0000);
        wait_idle();
        write_columns(5'd0);                        // render produces nothing
        send_item(OP_RENDER, 8'd255, 16'h0000);
        send_item(OP_LOAD, 8'd2, 16'hFFFF);
        wait_idle();
        write_columns(5'd31);                       // saturates to the full width
        send_item(OP_RENDER, 8'd1, 16'h0000);
        wait_idle();
        write_columns(5'd17);
        send_item(OP_RENDER, 8'd254, 16'h0000);
        wait_idle();
        write_columns(5'd2);                        // bits past the column count ignored
        send_item(OP_RENDER, 8'd17, 16'h0000);

        // Random phases: mostly load a neighborhood then render its middle row,
        // with some stray loads and renders anywhere in the map.
        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            wait_idle();
            case (phase % 4)
                0:       cols = COLS_W'($urandom_range(1, MAX_COLUMNS));
                1:       cols = COLS_W'($urandom_range(1, 4));
                2:       cols = COLS_RESET;
                default: cols = COLS_W'($urandom_range(0, 31));
            endcase
            write_columns(cols);
            case ($urandom_range(4))
                0:       anchor = 8'd0;
                1:       anchor = 8'd248;
                2:       anchor = 8'd12;
                3:       anchor = 8'd28;
                default: anchor = INDEX_W'($urandom_range(255));
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(99) < 70) begin
                    r = anchor + INDEX_W'($urandom_range(7));
                    if ($urandom_range(99) < 80) send_item(OP_LOAD, r - 8'd1, cell_pattern());
                    if ($urandom_range(99) < 80) send_item(OP_LOAD, r, cell_pattern());
                    if ($urandom_range(99) < 80) send_item(OP_LOAD, r + 8'd1, cell_pattern());
                    send_item(OP_RENDER, r, ROW_W'($urandom));
                end else begin
                    send_item($urandom_range(1) ? OP_RENDER : OP_LOAD,
                              INDEX_W'($urandom_range(255)), ROW_W'($urandom));
                end
            end
            phase++;
        end

        // Drain: every entry back, then a short tail to catch strays.
        wait_idle();
        if (sb.errors == 0) begin
            $display("bitmask_autotile_row_renderer_tb passed");
        end else begin
            $display("bitmask_autotile_row_renderer_tb failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/abtr_pkg.sv
hw/rtl/abtr_row_mem.sv
hw/rtl/abtr_entry_gen.sv
hw/rtl/bitmask_autotile_row_renderer.sv
dv/bitmask_autotile_row_renderer_tb.sv
